FILE: rtl/bf3_pkg.sv
// Shared constants for the 3x3 box filter stream block.
// No dependencies; imported by the top level.
package bf3_pkg;

    // Register map: index of each register, byte address is 4*index.
    typedef enum logic [0:0] {
        REG_IMAGE_COLS = 1'b0,
        REG_IMAGE_ROWS = 1'b1
    } t_reg_idx;

    localparam int ROWS_W = 16;

    // Mean scaling: sum * 7282 >> 16 with round to nearest, about sum / 9.
    localparam int MEAN_MUL_W = 14;
    localparam logic signed [MEAN_MUL_W-1:0] MEAN_MUL = 14'sd7282;
    localparam int MEAN_SHIFT = 16;

endpackage

FILE: rtl/bf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/box_filter_3x3_stream_top.sv
// 3x3 box (mean) filter over a raster-order pixel stream, top level.
// Depends on bf3_pkg and bf3_ram (two line buffers).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready   | i_pixel_in
//  out      | o_out_valid / i_out_ready | o_mean_out, o_out_col, o_out_row,
//           |                           | o_frame_last
//  config   | APB psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// One pixel per clock sustained while the output is not stalled. From input
// transaction to result: line-buffer read, window update, nine-term sum, scale multiply.
// Every stage has its own valid and advances when the next one is free, so
// bubbles collapse and a stalled output only backs up the stages behind it.
// Border pixels shift the window and update the line buffers but leave no
// result. Reset (synchronous, active low) clears counters, window and valids;
// the line buffers are not cleared.
module box_filter_3x3_stream_top #(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [PIXEL_BITS-1:0]  i_pixel_in,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [PIXEL_BITS-1:0]  o_mean_out,
    output logic [$clog2(MAX_COLS)-1:0]   o_out_col,
    output logic [bf3_pkg::ROWS_W-1:0]    o_out_row,
    output logic                          o_frame_last,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import bf3_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CFGC_W = $clog2(MAX_COLS + 1);
    localparam int SUM_W  = PIXEL_BITS + 4;
    localparam int PROD_W = SUM_W + MEAN_MUL_W;
    localparam int Q_W    = PROD_W - MEAN_SHIFT;

    localparam logic [CFGC_W-1:0] COLS_MIN  = CFGC_W'(3);
    localparam logic [CFGC_W-1:0] COLS_MAX  = CFGC_W'(MAX_COLS);
    localparam logic [COL_W-1:0]  IDX_LAST  = COL_W'(MAX_COLS - 1);
    localparam logic [ROWS_W-1:0] ROWS_MIN  = ROWS_W'(3);
    localparam logic [ROWS_W-1:0] ROWS_RST  = ROWS_W'(1024);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROWS_W-1:0] row;
        logic              last;
    } t_meta;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFGC_W-1:0] r_image_cols;
    logic [ROWS_W-1:0] r_image_rows;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= COLS_MAX;
            r_image_rows <= ROWS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IMAGE_COLS: r_image_cols <= pwdata[CFGC_W-1:0];
                REG_IMAGE_ROWS: r_image_rows <= pwdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMAGE_COLS: prdata = 32'(r_image_cols);
            REG_IMAGE_ROWS: prdata = 32'(r_image_rows);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic out_free, c_go, c_free, b_go, b_free, a_go, a_free, in_acc;

    assign out_free = !r_out_valid || i_out_ready;
    assign c_go     = r_c_valid && out_free;
    assign c_free   = !r_c_valid || c_go;
    assign b_go     = r_b_valid && c_free;
    assign b_free   = !r_b_valid || b_go;
    // window is overwritten when A advances, so B must be empty or leaving
    assign a_go     = r_a_valid && b_free;
    assign a_free   = !r_a_valid || a_go;
    assign in_acc   = i_in_valid && a_free;

    assign o_in_ready  = a_free;
    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Position counters, evaluated at the input transaction
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  r_col;
    logic [ROWS_W-1:0] r_row;
    logic [CFGC_W-1:0] eff_cols;
    logic [ROWS_W-1:0] eff_rows;
    logic              last_col, last_row;
    logic [COL_W-1:0]  rd_idx;
    t_meta             in_meta;
    logic              in_has_res;

    always_comb begin
        priority if (r_image_cols < COLS_MIN) begin
            eff_cols = COLS_MIN;
        end else if (r_image_cols > COLS_MAX) begin
            eff_cols = COLS_MAX;
        end else begin
            eff_cols = r_image_cols;
        end
        eff_rows = (r_image_rows < ROWS_MIN) ? ROWS_MIN : r_image_rows;
    end

    assign last_col      = CFGC_W'(r_col) >= (eff_cols - CFGC_W'(1));
    assign last_row      = r_row >= (eff_rows - ROWS_W'(1));
    assign rd_idx        = (r_col > IDX_LAST) ? IDX_LAST : r_col;
    assign in_has_res    = (r_row >= ROWS_W'(2)) && (r_col >= COL_W'(2));
    assign in_meta.col   = r_col - COL_W'(1);
    assign in_meta.row   = r_row - ROWS_W'(1);
    assign in_meta.last  = last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROWS_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: line-buffer read in flight
    // ------------------------------------------------------------------
    logic signed [PIXEL_BITS-1:0] r_a_pix;
    logic [COL_W-1:0]             r_a_idx;
    t_meta                        r_a_meta;
    logic                         r_a_res;
    logic [PIXEL_BITS-1:0]        up_data, mid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_pix  <= i_pixel_in;
            r_a_idx  <= rd_idx;
            r_a_meta <= in_meta;
            r_a_res  <= in_has_res;
        end
    end

    // read data holds while A is stalled since the read enable is the transaction
    bf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_line_upper (
        .i_clk     (i_clk),
        .i_wr_en   (a_go),
        .i_wr_addr (r_a_idx),
        .i_wr_data (mid_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_idx),
        .o_rd_data (up_data)
    );

    bf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_line_middle (
        .i_clk     (i_clk),
        .i_wr_en   (a_go),
        .i_wr_addr (r_a_idx),
        .i_wr_data (r_a_pix),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_idx),
        .o_rd_data (mid_data)
    );

    // ------------------------------------------------------------------
    // Stage B: 3x3 window, row 0 oldest line, column 2 newest
    // ------------------------------------------------------------------
    logic signed [PIXEL_BITS-1:0] r_win [0:8];
    t_meta                        r_b_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (a_go) begin
                r_b_valid <= r_a_res;
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3+0] <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= $signed(up_data);
                r_win[5] <= $signed(mid_data);
                r_win[8] <= r_a_pix;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_meta <= r_a_meta;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: nine-term sum
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] n_sum, r_sum;
    t_meta                   r_c_meta;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 9; k++) begin
            n_sum = n_sum + SUM_W'(r_win[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_sum    <= n_sum;
            r_c_meta <= r_b_meta;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: scale, round, saturate
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]     prod;
    logic signed [Q_W-1:0]        q;
    logic signed [PIXEL_BITS-1:0] n_mean, r_mean;
    t_meta                        r_o_meta;

    assign prod = PROD_W'(r_sum) * PROD_W'(MEAN_MUL)
                + (PROD_W'(1) <<< (MEAN_SHIFT - 1));
    assign q    = prod[PROD_W-1:MEAN_SHIFT];

    always_comb begin
        // in range when the bits above the sample sign all match it
        if (q[Q_W-1:PIXEL_BITS-1] == '0 || q[Q_W-1:PIXEL_BITS-1] == '1) begin
            n_mean = q[PIXEL_BITS-1:0];
        end else if (q[Q_W-1]) begin
            n_mean = {1'b1, {(PIXEL_BITS-1){1'b0}}};
        end else begin
            n_mean = {1'b0, {(PIXEL_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_go) begin
            r_mean   <= n_mean;
            r_o_meta <= r_c_meta;
        end
    end

    assign o_mean_out   = r_mean;
    assign o_out_col    = r_o_meta.col;
    assign o_out_row    = r_o_meta.row;
    assign o_frame_last = r_o_meta.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= IDX_LAST)
        else $error("column counter past last line-buffer entry");

    a_no_border_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_col != '0) && (o_out_row != '0))
        else $error("result on a border position");

    // case equality: unwritten line entries travel through the window as X
    a_window_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go |=> (r_win[0] === $past(r_win[1])) && (r_win[8] === $past(r_a_pix)))
        else $error("window did not shift on stage A advance");

    a_window_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_go) |=> (r_win[4] === $past(r_win[4])))
        else $error("window overwritten while its sum is pending");

endmodule

FILE: tb/tb_box_filter_3x3_stream_top.sv
// Self-checking testbench for the 3x3 box filter stream block.
// Needs bf3_pkg and box_filter_3x3_stream_top; an in-bench predictor of the
// window mean is scored against every output transaction.
`timescale 1ns / 1ps

module tb_box_filter_3x3_stream_top;
    import bf3_pkg::*;

    localparam int LINE_DEPTH     = 1024;
    localparam int PIX_W          = 16;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 240;
    localparam int WIDE_PIXELS    = 30;
    localparam int LONG_STALL     = 300;

    typedef enum int {
        PIX_RANDOM,
        PIX_EXTREME,
        PIX_NEAR_ZERO
    } t_pixel_mix;

    typedef struct packed {
        logic signed [PIX_W-1:0] mean;
        logic [9:0]              col;
        logic [15:0]             row;
        logic                    last;
        logic                    mean_known;
    } t_mean_result;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic signed [PIX_W-1:0] i_pixel_in   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic signed [PIX_W-1:0] o_mean_out;
    logic [9:0]              o_out_col;
    logic [15:0]             o_out_row;
    logic                    o_frame_last;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [2:0]              paddr        = '0;
    logic [31:0]             pwdata       = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // Predictor state
    logic signed [PIX_W-1:0] prev2_row [LINE_DEPTH];
    logic signed [PIX_W-1:0] prev1_row [LINE_DEPTH];
    logic signed [PIX_W-1:0] win [9];
    // line entries never written hold no defined value; such means are not scored
    bit                      prev2_known [LINE_DEPTH];
    bit                      prev1_known [LINE_DEPTH];
    bit                      win_known [9];
    logic [9:0]              next_col;
    logic [15:0]             next_row;
    logic [10:0]             cfg_cols;
    logic [15:0]             cfg_rows;
    t_mean_result            expected_means [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_off_cycles = 0;
    int error_count = 0;
    int pixels_sent = 0;
    int means_checked = 0;
    int frames_closed = 0;
    int size_writes = 0;
    int random_pixels = 0;
    int quiet_cycles = 0;

    box_filter_3x3_stream_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean_out   (o_mean_out),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned active_cols();
        if (cfg_cols < 3) return 3;
        if (cfg_cols > LINE_DEPTH) return LINE_DEPTH;
        return cfg_cols;
    endfunction

    function automatic int unsigned active_rows();
        return (cfg_rows < 3) ? 3 : cfg_rows;
    endfunction

    // Shift the window by one pixel, update both line stores and queue the
    // mean when the window center is an interior position.
    function automatic void advance_window(input logic signed [PIX_W-1:0] px);
        int unsigned  n_cols;
        int unsigned  n_rows;
        int unsigned  c;
        int unsigned  r;
        logic signed [PIX_W-1:0] above2;
        logic signed [PIX_W-1:0] above1;
        bit           above2_known;
        bit           above1_known;
        bit           all_known;
        longint       acc;
        longint       scaled;
        bit           end_col;
        bit           end_row;
        t_mean_result res;
        n_cols = active_cols();
        n_rows = active_rows();
        c = next_col;
        r = next_row;
        above2 = prev2_row[c];
        above1 = prev1_row[c];
        above2_known = prev2_known[c];
        above1_known = prev1_known[c];
        for (int k = 0; k < 3; k++) begin
            win[k*3]         = win[k*3+1];
            win[k*3+1]       = win[k*3+2];
            win_known[k*3]   = win_known[k*3+1];
            win_known[k*3+1] = win_known[k*3+2];
        end
        win[2] = above2;
        win[5] = above1;
        win[8] = px;
        win_known[2] = above2_known;
        win_known[5] = above1_known;
        win_known[8] = 1'b1;
        prev2_row[c] = above1;
        prev1_row[c] = px;
        prev2_known[c] = above1_known;
        prev1_known[c] = 1'b1;
        end_col = (c >= n_cols - 1);
        end_row = (r >= n_rows - 1);
        if (r >= 2 && c >= 2) begin
            acc = 0;
            all_known = 1'b1;
            for (int k = 0; k < 9; k++) begin
                acc += win[k];
                all_known &= win_known[k];
            end
            // arithmetic shift floors, so adding half first rounds ties upward
            scaled = (acc * longint'(MEAN_MUL) + (longint'(1) << (MEAN_SHIFT - 1)))
                     >>> MEAN_SHIFT;
            if (scaled > 32767)
                scaled = 32767;
            else if (scaled < -32768)
                scaled = -32768;
            res.mean       = scaled[PIX_W-1:0];
            res.col        = 10'(c - 1);
            res.row        = 16'(r - 1);
            res.last       = end_col && end_row;
            res.mean_known = all_known;
            expected_means.push_back(res);
        end
        if (end_col) begin
            next_col = '0;
            next_row = end_row ? 16'd0 : 16'(r + 1);
        end else begin
            next_col = 10'(c + 1);
        end
    endfunction

    function automatic logic signed [PIX_W-1:0] draw_pixel(input t_pixel_mix mix);
        int v;
        case (mix)
            PIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            PIX_NEAR_ZERO: begin
                v = $urandom_range(0, 64);
                return 16'(v - 32);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic signed [PIX_W-1:0] px);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_in_ready);
        advance_window(px);
        pixels_sent++;
    endtask

    // Stop input, let every queued mean come out, then cover border pixels
    // still in flight that leave no result behind.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Two back-to-back APB writes; psel stays high across both transactions.
    task automatic set_frame_size(input logic [31:0] cols_word, input logic [31:0] rows_word);
        t_reg_idx    idx;
        logic [31:0] word;
        drain_pipeline();
        psel   <= 1'b1;
        pwrite <= 1'b1;
        for (int i = 0; i < 2; i++) begin
            idx  = (i == 0) ? REG_IMAGE_COLS : REG_IMAGE_ROWS;
            word = (i == 0) ? cols_word : rows_word;
            penable <= 1'b0;
            paddr   <= {idx, 2'b00};
            pwdata  <= word;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            case (idx)
                REG_IMAGE_COLS: cfg_cols = word[10:0];
                REG_IMAGE_ROWS: cfg_rows = word[15:0];
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_writes++;
    endtask

    // Saturation at both rails plus the clamp of sizes below three.
    task automatic test_full_scale_frames();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_frame_size(32'd0, 32'd0);
        repeat (9) send_pixel(16'sh7FFF);
        set_frame_size(32'd2, 32'd2);
        repeat (9) send_pixel(16'sh8000);
        set_frame_size(32'd1, 32'd1);
        repeat (9) send_pixel(draw_pixel(PIX_EXTREME));
    endtask

    // Column count above the line depth clamps to the full line width.
    task automatic test_widest_row();
        set_frame_size(32'd2047, 32'd3);
        repeat (WIDE_PIXELS) send_pixel(draw_pixel(PIX_RANDOM));
    endtask

    task automatic test_resize_mid_frame();
        set_frame_size(32'd6, 32'd5);
        repeat (23) send_pixel(draw_pixel(PIX_RANDOM));
        // column counter sits past the new last column: wraps on next pixel
        set_frame_size(32'd4, 32'd5);
        send_pixel(draw_pixel(PIX_RANDOM));
        // row counter now past the new last row: frame closes after this row
        set_frame_size(32'd4, 32'd4);
        repeat (4) send_pixel(draw_pixel(PIX_RANDOM));
        set_frame_size(32'd3, 32'd3);
        repeat (4) send_pixel(draw_pixel(PIX_RANDOM));
        set_frame_size(32'd9, 32'd4);
        repeat (20) send_pixel(draw_pixel(PIX_NEAR_ZERO));
    endtask

    task automatic test_output_backpressure();
        set_frame_size(32'd5, 32'd6);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_off_cycles = LONG_STALL;
        repeat (60) send_pixel(draw_pixel(PIX_RANDOM));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        logic [31:0] cols_word;
        logic [31:0] rows_word;
        int unsigned n_cols;
        int unsigned n_rows;
        int unsigned c;
        int unsigned r;
        int unsigned count;
        bit          frame_done;
        t_pixel_mix  mix;
        while (random_pixels < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0: cols_word = $urandom_range(0, 2);
                1: cols_word = $urandom_range(LINE_DEPTH + 1, 2047);
                2: cols_word = 32'hFFFF_F800 | $urandom_range(3, 12);
                default: cols_word = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0: rows_word = $urandom_range(0, 2);
                1: rows_word = 32'hFFFF;
                default: rows_word = $urandom_range(3, 8);
            endcase
            set_frame_size(cols_word, rows_word);
            n_cols = active_cols();
            n_rows = active_rows();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                mix = PIX_EXTREME;
            else if ($urandom_range(0, 5) == 0)
                mix = PIX_NEAR_ZERO;
            else
                mix = PIX_RANDOM;

            if (n_cols > 64 || n_rows > 64) begin
                count = $urandom_range(1, 40);
            end else if ($urandom_range(0, 9) < 3) begin
                count = $urandom_range(1, 3 * n_cols);
            end else begin
                // run to the end of the current frame, then whole frames
                c = next_col;
                r = next_row;
                count = 0;
                frame_done = 1'b0;
                while (!frame_done) begin
                    count++;
                    if (c >= n_cols - 1) begin
                        c = 0;
                        if (r >= n_rows - 1)
                            frame_done = 1'b1;
                        else
                            r++;
                    end else begin
                        c++;
                    end
                end
                count += $urandom_range(0, 2) * n_cols * n_rows;
            end
            if (count > RANDOM_PIXELS - random_pixels)
                count = RANDOM_PIXELS - random_pixels;
            repeat (count) begin
                send_pixel(draw_pixel(mix));
                random_pixels++;
            end
        end
    endtask

    initial begin : output_ready_driver
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            stall = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_means
        t_mean_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_means.size() == 0) begin
                $error("unexpected result: mean_out %0d col %0d row %0d",
                       o_mean_out, o_out_col, o_out_row);
                error_count++;
            end else begin
                want = expected_means.pop_front();
                means_checked++;
                if (want.last)
                    frames_closed++;
                if (want.mean_known && o_mean_out !== want.mean) begin
                    $error("mean_out: expected %0d, actual %0d", want.mean, o_mean_out);
                    error_count++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, actual %0d", want.col, o_out_col);
                    error_count++;
                end
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, actual %0d", want.row, o_out_row);
                    error_count++;
                end
                if (o_frame_last !== want.last) begin
                    $error("frame_last: expected %0d, actual %0d", want.last, o_frame_last);
                    error_count++;
                end
            end
        end
    end

    // Any transaction on the input or output channel, or any config write, restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : main_sequence
        for (int i = 0; i < LINE_DEPTH; i++) begin
            prev2_row[i] = '0;
            prev1_row[i] = '0;
            prev2_known[i] = 1'b0;
            prev1_known[i] = 1'b0;
        end
        for (int k = 0; k < 9; k++) begin
            win[k] = '0;
            win_known[k] = 1'b1;
        end
        next_col = '0;
        next_row = '0;
        cfg_cols = 11'd1024;
        cfg_rows = 16'd1024;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_scale_frames();
        test_resize_mid_frame();
        test_output_backpressure();
        test_widest_row();
        test_random_frames();

        drain_pipeline();
        $display("Sent %0d pixels; checked %0d means, %0d of them frame ends, over %0d sizes.",
                 pixels_sent, means_checked, frames_closed, size_writes);
        $display("Covered rail sums, clamped and mid-frame sizes, wide rows and a %0d-cycle stall.",
                 LONG_STALL);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: box_filter_3x3_stream_top.f
rtl/bf3_pkg.sv
rtl/bf3_ram.sv
rtl/box_filter_3x3_stream_top.sv
tb/tb_box_filter_3x3_stream_top.sv
